// ----- design/ewp_pkg.sv -----
// Shared types, codes and helper function of the perspective-correct edge walker.
package ewp_pkg;

    localparam int unsigned DATA_W = 32;
    localparam int unsigned ROW_W = 16;
    localparam int unsigned FRAC_W = 16;
    localparam int unsigned S_TDATA_W = 7 * DATA_W;
    localparam int unsigned M_TDATA_W = 4 * DATA_W + 2 * ROW_W;
    localparam int unsigned CFG_INDEX_W = 3;

    localparam int unsigned DIV_STEPS = 49;
    localparam int unsigned DIV_CNT_W = 6;
    localparam logic [DIV_CNT_W-1:0] DIV_LAST = DIV_CNT_W'(DIV_STEPS - 1);

    localparam logic [CFG_INDEX_W-1:0] CFG_U_GRAD_DX = 3'd0;
    localparam logic [CFG_INDEX_W-1:0] CFG_U_GRAD_DY = 3'd1;
    localparam logic [CFG_INDEX_W-1:0] CFG_V_GRAD_DX = 3'd2;
    localparam logic [CFG_INDEX_W-1:0] CFG_V_GRAD_DY = 3'd3;
    localparam logic [CFG_INDEX_W-1:0] CFG_W_GRAD_DX = 3'd4;
    localparam logic [CFG_INDEX_W-1:0] CFG_W_GRAD_DY = 3'd5;

    typedef logic [1:0] chan_t;
    localparam chan_t CH_U = 2'd0;
    localparam chan_t CH_V = 2'd1;
    localparam chan_t CH_W = 2'd2;

    localparam logic REQ_SETUP = 1'b0;
    localparam logic REQ_STEP = 1'b1;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_STEP,
        ST_PRE,
        ST_DIV,
        ST_SLOPE,
        ST_MUL_X,
        ST_ACC_X,
        ST_MUL_GX,
        ST_ACC_GX,
        ST_MUL_GY,
        ST_ACC_GY,
        ST_MUL_GS,
        ST_ACC_GS,
        ST_WRITE
    } state_t;

    typedef enum logic [1:0] {
        MSEL_YPRE_SLOPE,
        MSEL_GDX_XPRE,
        MSEL_GDY_YPRE,
        MSEL_GDX_SLOPE
    } mul_sel_t;

    typedef enum logic [2:0] {
        ACC_NONE,
        ACC_X,
        ACC_GX,
        ACC_GY,
        ACC_GS
    } acc_op_t;

    typedef struct packed {
        logic     capture;
        logic     pre;
        logic     div_step;
        logic     slope_load;
        logic     mul_en;
        mul_sel_t mul_sel;
        acc_op_t  acc_op;
        chan_t    chan;
        logic     row_step;
        logic     out_load;
    } cmd_t;

    typedef struct packed {
        logic out_free;
    } status_t;

    function automatic logic signed [DATA_W-1:0] sat32(input logic signed [63:0] v);
        logic signed [63:0] max_v;
        logic signed [63:0] min_v;
        max_v = 64'sh0000_0000_7FFF_FFFF;
        min_v = -64'sh0000_0000_8000_0000;
        if (v > max_v) begin
            return 32'sh7FFF_FFFF;
        end else if (v < min_v) begin
            return 32'sh8000_0000;
        end
        return v[DATA_W-1:0];
    endfunction

endpackage

// ----- design/edge_walker_perspective.sv -----
// Top level of the perspective-correct scanline edge walker.
// A step transaction passes through the sequencer states for accept, row add and result write.
// A setup transaction passes through the bit-serial slope divider and then the shared
// multiplier in sequential multiply and accumulate steps; one transaction is in work at a time.
// Reset is synchronous and active low; it clears gradients, edge state and the output valid.
module edge_walker_perspective (
    input  logic                                  aclk,
    input  logic                                  aresetn,
    input  logic                                  s_tvalid,
    output logic                                  s_tready,
    // Fields from bit 0: top_x, top_y, bottom_x, bottom_y, top_u, top_v, top_inv_z.
    input  logic [ewp_pkg::S_TDATA_W-1:0]         s_tdata,
    // Fields from bit 0: req_type.
    input  logic                                  s_tuser,
    output logic                                  m_tvalid,
    input  logic                                  m_tready,
    // Fields from bit 0: edge_x, edge_u, edge_v, edge_inv_z, row_first, row_last.
    output logic [ewp_pkg::M_TDATA_W-1:0]         m_tdata,
    input  logic                                  cfg_valid,
    output logic                                  cfg_ready,
    input  logic [ewp_pkg::CFG_INDEX_W-1:0]       cfg_index,
    input  logic [ewp_pkg::DATA_W-1:0]            cfg_data
);

    ewp_pkg::cmd_t    cmd;
    ewp_pkg::status_t status;

    assign cfg_ready = 1'b1;

    ewp_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tuser  (s_tuser),
        .status   (status),
        .cmd      (cmd)
    );

    ewp_dp u_dp (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cmd       (cmd),
        .status    (status),
        .s_tdata   (s_tdata),
        .cfg_valid (cfg_valid),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata)
    );

endmodule

// ----- design/ewp_div.sv -----
// Restoring divider for the edge slope, one quotient bit per cycle while step is high, on magnitudes.
module ewp_div (
    input  logic        aclk,
    input  logic        init,
    input  logic        step,
    input  logic [48:0] dividend,
    input  logic [32:0] divisor,
    output logic [48:0] quotient
);

    logic [48:0] quo_reg;
    logic [48:0] quo_next;
    logic [32:0] rem_reg;
    logic [32:0] rem_next;
    logic [32:0] den_reg;
    logic [33:0] rem_shift;
    logic [34:0] trial;

    always_comb begin
        rem_shift = {rem_reg, quo_reg[48]};
        trial = {1'b0, rem_shift} - {2'b00, den_reg};
        if (!trial[34]) begin
            rem_next = trial[32:0];
            quo_next = {quo_reg[47:0], 1'b1};
        end else begin
            rem_next = rem_shift[32:0];
            quo_next = {quo_reg[47:0], 1'b0};
        end
    end

    always_ff @(posedge aclk) begin
        if (init) begin
            quo_reg <= dividend;
            rem_reg <= '0;
            den_reg <= divisor;
        end else if (step) begin
            quo_reg <= quo_next;
            rem_reg <= rem_next;
        end
    end

    assign quotient = quo_reg;

endmodule

// ----- design/ewp_ctrl.sv -----
// Sequencer of the edge walker: accepts transactions and issues datapath commands.
module ewp_ctrl (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              s_tvalid,
    output logic              s_tready,
    input  logic              s_tuser,
    input  ewp_pkg::status_t  status,
    output ewp_pkg::cmd_t     cmd
);

    ewp_pkg::state_t                 state_reg;
    ewp_pkg::state_t                 state_next;
    logic [ewp_pkg::DIV_CNT_W-1:0]   div_cnt_reg;
    logic [ewp_pkg::DIV_CNT_W-1:0]   div_cnt_next;
    ewp_pkg::chan_t                  chan_reg;
    ewp_pkg::chan_t                  chan_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ewp_pkg::ST_IDLE;
            div_cnt_reg <= '0;
            chan_reg <= ewp_pkg::CH_U;
        end else begin
            state_reg <= state_next;
            div_cnt_reg <= div_cnt_next;
            chan_reg <= chan_next;
        end
    end

    always_comb begin
        state_next = state_reg;
        div_cnt_next = div_cnt_reg;
        chan_next = chan_reg;
        s_tready = 1'b0;
        cmd = '0;
        cmd.mul_sel = ewp_pkg::MSEL_YPRE_SLOPE;
        cmd.acc_op = ewp_pkg::ACC_NONE;
        cmd.chan = chan_reg;
        case (state_reg)
            ewp_pkg::ST_IDLE: begin
                s_tready = 1'b1;
                if (s_tvalid) begin
                    cmd.capture = 1'b1;
                    state_next = (s_tuser == ewp_pkg::REQ_STEP) ? ewp_pkg::ST_STEP
                                                               : ewp_pkg::ST_PRE;
                end
            end
            ewp_pkg::ST_STEP: begin
                cmd.row_step = 1'b1;
                state_next = ewp_pkg::ST_WRITE;
            end
            ewp_pkg::ST_PRE: begin
                cmd.pre = 1'b1;
                div_cnt_next = '0;
                chan_next = ewp_pkg::CH_U;
                state_next = ewp_pkg::ST_DIV;
            end
            ewp_pkg::ST_DIV: begin
                cmd.div_step = 1'b1;
                div_cnt_next = div_cnt_reg + 1'b1;
                if (div_cnt_reg == ewp_pkg::DIV_LAST) begin
                    state_next = ewp_pkg::ST_SLOPE;
                end
            end
            ewp_pkg::ST_SLOPE: begin
                cmd.slope_load = 1'b1;
                state_next = ewp_pkg::ST_MUL_X;
            end
            ewp_pkg::ST_MUL_X: begin
                cmd.mul_en = 1'b1;
                cmd.mul_sel = ewp_pkg::MSEL_YPRE_SLOPE;
                state_next = ewp_pkg::ST_ACC_X;
            end
            ewp_pkg::ST_ACC_X: begin
                cmd.acc_op = ewp_pkg::ACC_X;
                state_next = ewp_pkg::ST_MUL_GX;
            end
            ewp_pkg::ST_MUL_GX: begin
                cmd.mul_en = 1'b1;
                cmd.mul_sel = ewp_pkg::MSEL_GDX_XPRE;
                state_next = ewp_pkg::ST_ACC_GX;
            end
            ewp_pkg::ST_ACC_GX: begin
                cmd.acc_op = ewp_pkg::ACC_GX;
                state_next = ewp_pkg::ST_MUL_GY;
            end
            ewp_pkg::ST_MUL_GY: begin
                cmd.mul_en = 1'b1;
                cmd.mul_sel = ewp_pkg::MSEL_GDY_YPRE;
                state_next = ewp_pkg::ST_ACC_GY;
            end
            ewp_pkg::ST_ACC_GY: begin
                cmd.acc_op = ewp_pkg::ACC_GY;
                state_next = ewp_pkg::ST_MUL_GS;
            end
            ewp_pkg::ST_MUL_GS: begin
                cmd.mul_en = 1'b1;
                cmd.mul_sel = ewp_pkg::MSEL_GDX_SLOPE;
                state_next = ewp_pkg::ST_ACC_GS;
            end
            ewp_pkg::ST_ACC_GS: begin
                cmd.acc_op = ewp_pkg::ACC_GS;
                if (chan_reg == ewp_pkg::CH_W) begin
                    state_next = ewp_pkg::ST_WRITE;
                end else begin
                    chan_next = chan_reg + 1'b1;
                    state_next = ewp_pkg::ST_MUL_GX;
                end
            end
            ewp_pkg::ST_WRITE: begin
                if (status.out_free) begin
                    cmd.out_load = 1'b1;
                    state_next = ewp_pkg::ST_IDLE;
                end
            end
            default: begin
                state_next = ewp_pkg::ST_IDLE;
            end
        endcase
    end

endmodule

// ----- design/ewp_dp.sv -----
// Datapath of the edge walker: gradient registers, edge state, shared multiplier and output stage.
module ewp_dp (
    input  logic                                  aclk,
    input  logic                                  aresetn,
    input  ewp_pkg::cmd_t                         cmd,
    output ewp_pkg::status_t                      status,
    input  logic [ewp_pkg::S_TDATA_W-1:0]         s_tdata,
    input  logic                                  cfg_valid,
    input  logic [ewp_pkg::CFG_INDEX_W-1:0]       cfg_index,
    input  logic [ewp_pkg::DATA_W-1:0]            cfg_data,
    output logic                                  m_tvalid,
    input  logic                                  m_tready,
    output logic [ewp_pkg::M_TDATA_W-1:0]         m_tdata
);

    logic signed [31:0] gdx_reg [3];
    logic signed [31:0] gdy_reg [3];
    logic signed [31:0] cur_uvw_reg [3];
    logic signed [31:0] row_inc_reg [3];
    logic signed [31:0] base_reg [3];
    logic signed [31:0] cur_x_reg;
    logic signed [31:0] slope_reg;
    logic [15:0]        first_row_reg;
    logic [15:0]        end_row_reg;

    logic signed [31:0] tx_reg;
    logic signed [31:0] ty_reg;
    logic signed [31:0] bx_reg;
    logic signed [31:0] by_reg;
    logic [15:0]        ypre_reg;
    logic               neg_reg;
    logic               zero_reg;
    logic signed [65:0] prod_reg;
    logic signed [51:0] acc_reg;

    logic               m_tvalid_reg;
    logic [31:0]        out_x_reg;
    logic [31:0]        out_u_reg;
    logic [31:0]        out_v_reg;
    logic [31:0]        out_w_reg;
    logic [15:0]        out_first_reg;
    logic [15:0]        out_last_reg;

    logic signed [32:0] ty_ceil;
    logic signed [32:0] by_ceil;
    logic signed [32:0] xdist;
    logic signed [32:0] ydist;
    logic [32:0]        xmag;
    logic [32:0]        ymag;
    logic [48:0]        quotient;
    logic signed [49:0] slope_wide;
    logic signed [32:0] xpre;
    logic signed [32:0] mul_a;
    logic signed [32:0] mul_b;
    logic signed [49:0] prod_sh;
    logic signed [31:0] gdx_sel;
    logic signed [31:0] gdy_sel;
    logic signed [31:0] base_sel;

    assign ty_ceil = {ty_reg[31], ty_reg} + 33'sd65535;
    assign by_ceil = {by_reg[31], by_reg} + 33'sd65535;
    assign xdist = {bx_reg[31], bx_reg} - {tx_reg[31], tx_reg};
    assign ydist = {by_reg[31], by_reg} - {ty_reg[31], ty_reg};
    assign xmag = xdist[32] ? (33'd0 - xdist) : xdist;
    assign ymag = ydist[32] ? (33'd0 - ydist) : ydist;

    ewp_div u_div (
        .aclk     (aclk),
        .init     (cmd.pre),
        .step     (cmd.div_step),
        .dividend ({xmag, 16'd0}),
        .divisor  (ymag),
        .quotient (quotient)
    );

    assign slope_wide = neg_reg ? (50'sd0 - {1'b0, quotient}) : {1'b0, quotient};
    assign xpre = {cur_x_reg[31], cur_x_reg} - {tx_reg[31], tx_reg};
    assign prod_sh = prod_reg[65:16];
    assign gdx_sel = gdx_reg[cmd.chan];
    assign gdy_sel = gdy_reg[cmd.chan];
    assign base_sel = base_reg[cmd.chan];

    always_comb begin
        case (cmd.mul_sel)
            ewp_pkg::MSEL_YPRE_SLOPE: begin
                mul_a = {17'd0, ypre_reg};
                mul_b = {slope_reg[31], slope_reg};
            end
            ewp_pkg::MSEL_GDX_XPRE: begin
                mul_a = {gdx_sel[31], gdx_sel};
                mul_b = xpre;
            end
            ewp_pkg::MSEL_GDY_YPRE: begin
                mul_a = {gdy_sel[31], gdy_sel};
                mul_b = {17'd0, ypre_reg};
            end
            ewp_pkg::MSEL_GDX_SLOPE: begin
                mul_a = {gdx_sel[31], gdx_sel};
                mul_b = {slope_reg[31], slope_reg};
            end
            default: begin
                mul_a = '0;
                mul_b = '0;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (cmd.capture) begin
            tx_reg <= s_tdata[31:0];
            ty_reg <= s_tdata[63:32];
            bx_reg <= s_tdata[95:64];
            by_reg <= s_tdata[127:96];
            base_reg[ewp_pkg::CH_U] <= s_tdata[159:128];
            base_reg[ewp_pkg::CH_V] <= s_tdata[191:160];
            base_reg[ewp_pkg::CH_W] <= s_tdata[223:192];
        end
        if (cmd.pre) begin
            ypre_reg <= 16'd0 - ty_reg[15:0];
            neg_reg <= xdist[32] ^ ydist[32];
            zero_reg <= (ydist == 33'sd0);
        end
        if (cmd.mul_en) begin
            prod_reg <= mul_a * mul_b;
        end
        if (cmd.acc_op == ewp_pkg::ACC_GX) begin
            acc_reg <= 52'(base_sel) + 52'(prod_sh);
        end
    end

    assign status.out_free = !m_tvalid_reg || m_tready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            gdx_reg[ewp_pkg::CH_U] <= '0;
            gdx_reg[ewp_pkg::CH_V] <= '0;
            gdx_reg[ewp_pkg::CH_W] <= '0;
            gdy_reg[ewp_pkg::CH_U] <= '0;
            gdy_reg[ewp_pkg::CH_V] <= '0;
            gdy_reg[ewp_pkg::CH_W] <= '0;
            cur_uvw_reg[ewp_pkg::CH_U] <= '0;
            cur_uvw_reg[ewp_pkg::CH_V] <= '0;
            cur_uvw_reg[ewp_pkg::CH_W] <= '0;
            row_inc_reg[ewp_pkg::CH_U] <= '0;
            row_inc_reg[ewp_pkg::CH_V] <= '0;
            row_inc_reg[ewp_pkg::CH_W] <= '0;
            cur_x_reg <= '0;
            slope_reg <= '0;
            first_row_reg <= '0;
            end_row_reg <= '0;
            m_tvalid_reg <= 1'b0;
        end else begin
            if (cfg_valid) begin
                case (cfg_index)
                    ewp_pkg::CFG_U_GRAD_DX: gdx_reg[ewp_pkg::CH_U] <= cfg_data;
                    ewp_pkg::CFG_U_GRAD_DY: gdy_reg[ewp_pkg::CH_U] <= cfg_data;
                    ewp_pkg::CFG_V_GRAD_DX: gdx_reg[ewp_pkg::CH_V] <= cfg_data;
                    ewp_pkg::CFG_V_GRAD_DY: gdy_reg[ewp_pkg::CH_V] <= cfg_data;
                    ewp_pkg::CFG_W_GRAD_DX: gdx_reg[ewp_pkg::CH_W] <= cfg_data;
                    ewp_pkg::CFG_W_GRAD_DY: gdy_reg[ewp_pkg::CH_W] <= cfg_data;
                    default: begin
                    end
                endcase
            end
            if (cmd.pre) begin
                first_row_reg <= ty_ceil[31:16];
                end_row_reg <= by_ceil[31:16];
            end
            if (cmd.slope_load) begin
                slope_reg <= zero_reg ? 32'sd0 : ewp_pkg::sat32(64'(slope_wide));
            end
            case (cmd.acc_op)
                ewp_pkg::ACC_X: begin
                    cur_x_reg <= ewp_pkg::sat32(64'(tx_reg) + 64'(prod_sh));
                end
                ewp_pkg::ACC_GY: begin
                    cur_uvw_reg[cmd.chan] <= ewp_pkg::sat32(64'(acc_reg) + 64'(prod_sh));
                end
                ewp_pkg::ACC_GS: begin
                    row_inc_reg[cmd.chan] <= ewp_pkg::sat32(64'(gdy_sel) + 64'(prod_sh));
                end
                default: begin
                end
            endcase
            if (cmd.row_step) begin
                cur_x_reg <= ewp_pkg::sat32(64'(cur_x_reg) + 64'(slope_reg));
                cur_uvw_reg[ewp_pkg::CH_U] <= ewp_pkg::sat32(
                    64'(cur_uvw_reg[ewp_pkg::CH_U]) + 64'(row_inc_reg[ewp_pkg::CH_U]));
                cur_uvw_reg[ewp_pkg::CH_V] <= ewp_pkg::sat32(
                    64'(cur_uvw_reg[ewp_pkg::CH_V]) + 64'(row_inc_reg[ewp_pkg::CH_V]));
                cur_uvw_reg[ewp_pkg::CH_W] <= ewp_pkg::sat32(
                    64'(cur_uvw_reg[ewp_pkg::CH_W]) + 64'(row_inc_reg[ewp_pkg::CH_W]));
            end
            if (cmd.out_load) begin
                m_tvalid_reg <= 1'b1;
            end else if (m_tready) begin
                m_tvalid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.out_load) begin
            out_x_reg <= cur_x_reg;
            out_u_reg <= cur_uvw_reg[ewp_pkg::CH_U];
            out_v_reg <= cur_uvw_reg[ewp_pkg::CH_V];
            out_w_reg <= cur_uvw_reg[ewp_pkg::CH_W];
            out_first_reg <= first_row_reg;
            out_last_reg <= end_row_reg;
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata = {out_last_reg, out_first_reg, out_w_reg, out_v_reg, out_u_reg, out_x_reg};

endmodule
